// ===== rtl/motor_pair_sync_pid_assert.svh =====
// ----------------------------------------------------------------------------
// motor_pair_sync_pid assertion macros
// Concurrent assertion wrappers, empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MOTOR_PAIR_SYNC_PID_ASSERT_SVH
`define MOTOR_PAIR_SYNC_PID_ASSERT_SVH

`ifndef SYNTH

// checked on clk, masked while rst is high
`define MPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("motor_pair_sync_pid: assertion failed");

// checked on clk, also during reset
`define MPS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("motor_pair_sync_pid: assertion failed");

`else

`define MPS_ASSERT(lbl, prop)
`define MPS_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== rtl/mps_pkg.sv =====
// ----------------------------------------------------------------------------
// mps_pkg
// Shared constants, types and control structs of the motor pair sync PID.
// ----------------------------------------------------------------------------
package mps_pkg;

  localparam int DEGREE_BITS    = 20;
  localparam int FRAC_BITS      = 8;
  localparam int INTEGRAL_LIMIT = 100;

  localparam int REG_W      = 16;
  localparam int REG_CNT    = 7;
  localparam int REG_IDX_W  = 3;
  localparam int RATIO_FRAC = 12;
  localparam int GAIN_FRAC  = 8;
  localparam int SF         = FRAC_BITS + GAIN_FRAC;   // steer fraction bits
  localparam int SPEED_W    = 8;
  localparam int DRIVE_W    = 8;
  localparam int STEER_W    = 16;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_RATIO  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GP_NRM = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GI_NRM = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GD_NRM = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GP_TNK = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_GI_TNK = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_GD_TNK = 3'd6;
  localparam logic [REG_W-1:0]     RATIO_RESET = REG_W'(1 << RATIO_FRAC);

  // error division: |fast*ratio| fits DEGREE_BITS+15 bits, quotient < 2^Q_W
  localparam int MAG_W = DEGREE_BITS + REG_W - 1;
  localparam int N_W   = MAG_W + FRAC_BITS;
  localparam int Q_W   = N_W - RATIO_FRAC;
  localparam int DEN_W = REG_W;
  localparam int CNT_W = $clog2(Q_W);

  localparam int ERR_W   = Q_W + 1;
  localparam int INTEG_W = 16;
  localparam int INT_LIM = INTEGRAL_LIMIT << FRAC_BITS;

  // shared multiplier
  localparam int MUL_A_W = ERR_W + 1;
  localparam int MUL_B_W = REG_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 2;

  localparam int IN_W   = 2 * DEGREE_BITS + SPEED_W;
  localparam int USER_W = 2;
  localparam int OUT_W  = STEER_W + 2 * DRIVE_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_DIV_LOAD,
    ST_DIV,
    ST_ERR,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_MUL_S,
    ST_FIN,
    ST_DONE
  } mps_state_t;

  typedef enum logic [2:0] {
    MUL_FAST,
    MUL_ERR_P,
    MUL_INT_I,
    MUL_DIFF_D,
    MUL_SPEED
  } mps_mul_sel_t;

  typedef struct packed {
    logic         load_in;
    logic         mul_en;
    mps_mul_sel_t mul_sel;
    logic         div_start;
    logic         err_upd;
    logic         acc_load;
    logic         acc_add;
    logic         last_upd;
    logic         fin_en;
    logic         out_load;
  } mps_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_full;
  } mps_sts_t;

endpackage

// ===== rtl/mps_div.sv =====
// ----------------------------------------------------------------------------
// mps_div
// Restoring divider, one quotient bit per cycle, unsigned.
// ----------------------------------------------------------------------------
module mps_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [mps_pkg::N_W-1:0]      dividend,
  input  logic [mps_pkg::DEN_W-1:0]    divisor,
  output logic [mps_pkg::Q_W-1:0]      quotient,
  output logic                         done
);

  logic [mps_pkg::DEN_W-1:0] rem;
  logic [mps_pkg::DEN_W-1:0] den;
  logic [mps_pkg::Q_W-1:0]   nq;       // dividend bits in, quotient bits out
  logic [mps_pkg::CNT_W-1:0] cnt;
  logic                      busy;

  logic [mps_pkg::DEN_W:0]   trial;
  logic                      ge;

  always_comb begin
    trial = {rem, nq[mps_pkg::Q_W-1]};
    ge    = (trial >= {1'b0, den});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= mps_pkg::CNT_W'(mps_pkg::Q_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // top bits are below the divisor since divisor >= 2^RATIO_FRAC
      rem <= mps_pkg::DEN_W'(dividend[mps_pkg::N_W-1:mps_pkg::Q_W]);
      nq  <= dividend[mps_pkg::Q_W-1:0];
      den <= divisor;
    end else if (busy) begin
      rem <= ge ? mps_pkg::DEN_W'(trial - {1'b0, den}) : trial[mps_pkg::DEN_W-1:0];
      nq  <= {nq[mps_pkg::Q_W-2:0], ge};
    end
  end

  assign quotient = nq;

  `include "motor_pair_sync_pid_assert.svh"

  `MPS_ASSERT(a_div_rem_below_den, busy |-> (rem < den))
  `MPS_ASSERT(a_div_start_busy, start |=> (busy && !done))

endmodule

// ===== rtl/mps_ctrl.sv =====
// ----------------------------------------------------------------------------
// mps_ctrl
// Sequencer: input transaction, divide, shared-multiplier PID passes, output.
// ----------------------------------------------------------------------------
module mps_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mps_pkg::mps_sts_t sts,
  output mps_pkg::mps_cmd_t cmd
);

  mps_pkg::mps_state_t state;
  mps_pkg::mps_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mps_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mps_pkg::ST_IDLE:     if (in_valid) state_next = mps_pkg::ST_MUL_A;
      mps_pkg::ST_MUL_A:    state_next = mps_pkg::ST_DIV_LOAD;
      mps_pkg::ST_DIV_LOAD: state_next = mps_pkg::ST_DIV;
      mps_pkg::ST_DIV:      if (sts.div_done) state_next = mps_pkg::ST_ERR;
      mps_pkg::ST_ERR:      state_next = mps_pkg::ST_MUL_P;
      mps_pkg::ST_MUL_P:    state_next = mps_pkg::ST_MUL_I;
      mps_pkg::ST_MUL_I:    state_next = mps_pkg::ST_MUL_D;
      mps_pkg::ST_MUL_D:    state_next = mps_pkg::ST_MUL_S;
      mps_pkg::ST_MUL_S:    state_next = mps_pkg::ST_FIN;
      mps_pkg::ST_FIN:      state_next = mps_pkg::ST_DONE;
      mps_pkg::ST_DONE:     if (!sts.out_full) state_next = mps_pkg::ST_IDLE;
      default:              state_next = mps_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd         = '0;
    cmd.mul_sel = mps_pkg::MUL_FAST;
    in_ready    = 1'b0;
    unique case (state)
      mps_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      mps_pkg::ST_MUL_A: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mps_pkg::MUL_FAST;
      end
      mps_pkg::ST_DIV_LOAD: cmd.div_start = 1'b1;
      mps_pkg::ST_DIV: begin
      end
      mps_pkg::ST_ERR: cmd.err_upd = 1'b1;
      mps_pkg::ST_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mps_pkg::MUL_ERR_P;
      end
      mps_pkg::ST_MUL_I: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = mps_pkg::MUL_INT_I;
        cmd.acc_load = 1'b1;
      end
      mps_pkg::ST_MUL_D: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_sel  = mps_pkg::MUL_DIFF_D;
        cmd.acc_add  = 1'b1;
        cmd.last_upd = 1'b1;
      end
      mps_pkg::ST_MUL_S: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = mps_pkg::MUL_SPEED;
        cmd.acc_add = 1'b1;
      end
      mps_pkg::ST_FIN:  cmd.fin_en = 1'b1;
      mps_pkg::ST_DONE: cmd.out_load = !sts.out_full;
      default: begin
      end
    endcase
  end

  `include "motor_pair_sync_pid_assert.svh"

  `MPS_ASSERT(a_ctrl_div_done_in_div, sts.div_done |-> (state == mps_pkg::ST_DIV))

endmodule

// ===== rtl/mps_dp.sv =====
// ----------------------------------------------------------------------------
// mps_dp
// Datapath: config registers, error divide, integral, shared multiplier,
// steer accumulator, drive shaping and output register.
// ----------------------------------------------------------------------------
module mps_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  mps_pkg::mps_cmd_t                 cmd,
  output mps_pkg::mps_sts_t                 sts,
  input  logic                              cfg_we,
  input  logic [mps_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [mps_pkg::REG_W-1:0]         cfg_wdata,
  input  logic [mps_pkg::IN_W-1:0]          in_data,
  input  logic [mps_pkg::USER_W-1:0]        in_user,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mps_pkg::OUT_W-1:0]         out_data
);

  localparam int ACC_W = mps_pkg::ACC_W;
  localparam int SF    = mps_pkg::SF;
  localparam logic signed [ACC_W-1:0] DRIVE_HI = ACC_W'(100);
  localparam logic signed [ACC_W-1:0] DRIVE_LO = -DRIVE_HI;
  localparam logic signed [ACC_W-1:0] STEER_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] STEER_LO = -STEER_HI - ACC_W'(1);
  localparam logic signed [mps_pkg::ERR_W:0] INT_HI = (mps_pkg::ERR_W + 1)'(mps_pkg::INT_LIM);
  localparam logic signed [mps_pkg::ERR_W:0] INT_LO = -INT_HI;

  // truncate toward zero by SF bits
  function automatic logic signed [ACC_W-1:0] trunc_sf(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] q;
    q = x >>> SF;
    if (x[ACC_W-1] && (x[SF-1:0] != '0)) q = q + ACC_W'(1);
    return q;
  endfunction

  function automatic logic [mps_pkg::DRIVE_W-1:0] sat_drive(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    y = (x > DRIVE_HI) ? DRIVE_HI : ((x < DRIVE_LO) ? DRIVE_LO : x);
    return y[mps_pkg::DRIVE_W-1:0];
  endfunction

  function automatic logic [mps_pkg::STEER_W-1:0] sat_steer(input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W-1:0] y;
    y = (x > STEER_HI) ? STEER_HI : ((x < STEER_LO) ? STEER_LO : x);
    return y[mps_pkg::STEER_W-1:0];
  endfunction

  // configuration
  logic [mps_pkg::REG_W-1:0] cfg_reg [mps_pkg::REG_CNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mps_pkg::REG_CNT; i++) begin
        if (i == int'(mps_pkg::REG_RATIO)) begin
          cfg_reg[i] <= mps_pkg::RATIO_RESET;
        end else begin
          cfg_reg[i] <= '0;
        end
      end
    end else if (cfg_we && (32'(cfg_index) < mps_pkg::REG_CNT)) begin
      cfg_reg[cfg_index] <= cfg_wdata;
    end
  end

  // captured input
  logic [mps_pkg::DEGREE_BITS-1:0]  fast;
  logic [mps_pkg::DEGREE_BITS-1:0]  slow;
  logic signed [mps_pkg::SPEED_W-1:0] speed;
  logic                             tank;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      fast  <= in_data[mps_pkg::DEGREE_BITS-1:0];
      slow  <= in_data[2*mps_pkg::DEGREE_BITS-1:mps_pkg::DEGREE_BITS];
      speed <= in_data[mps_pkg::IN_W-1:2*mps_pkg::DEGREE_BITS];
      tank  <= in_user[0];
    end
  end

  logic signed [mps_pkg::REG_W-1:0] ratio;
  logic [mps_pkg::REG_W-1:0]        abs_ratio;
  logic [mps_pkg::SPEED_W-1:0]      abs_speed;
  logic                             ratio_zero;
  logic                             speed_zero;
  logic signed [mps_pkg::REG_W-1:0] kp;
  logic signed [mps_pkg::REG_W-1:0] ki;
  logic signed [mps_pkg::REG_W-1:0] kd;

  always_comb begin
    ratio      = cfg_reg[mps_pkg::REG_RATIO];
    abs_ratio  = ratio[mps_pkg::REG_W-1] ? (~ratio + 1'b1) : ratio;
    abs_speed  = speed[mps_pkg::SPEED_W-1] ? (~speed + 1'b1) : speed;
    ratio_zero = (ratio == '0);
    speed_zero = (speed == '0);
    kp = tank ? cfg_reg[mps_pkg::REG_GP_TNK] : cfg_reg[mps_pkg::REG_GP_NRM];
    ki = tank ? cfg_reg[mps_pkg::REG_GI_TNK] : cfg_reg[mps_pkg::REG_GI_NRM];
    kd = tank ? cfg_reg[mps_pkg::REG_GD_TNK] : cfg_reg[mps_pkg::REG_GD_NRM];
  end

  // PID state
  logic signed [mps_pkg::ERR_W-1:0]   err;
  logic signed [mps_pkg::ERR_W-1:0]   last_err;
  logic signed [mps_pkg::INTEG_W-1:0] integ;
  logic                               err_neg;

  // shared multiplier
  logic signed [mps_pkg::MUL_A_W-1:0] mul_a;
  logic signed [mps_pkg::MUL_B_W-1:0] mul_b;
  logic signed [mps_pkg::PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]            acc;
  logic signed [ACC_W-1:0]            prod_ext;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.mul_sel)
      mps_pkg::MUL_FAST: begin
        mul_a = $signed(mps_pkg::MUL_A_W'(fast));
        mul_b = $signed({1'b0, abs_ratio});
      end
      mps_pkg::MUL_ERR_P: begin
        mul_a = {err[mps_pkg::ERR_W-1], err};
        mul_b = {kp[mps_pkg::REG_W-1], kp};
      end
      mps_pkg::MUL_INT_I: begin
        mul_a = mps_pkg::MUL_A_W'(integ);
        mul_b = {ki[mps_pkg::REG_W-1], ki};
      end
      mps_pkg::MUL_DIFF_D: begin
        mul_a = {err[mps_pkg::ERR_W-1], err} - {last_err[mps_pkg::ERR_W-1], last_err};
        mul_b = {kd[mps_pkg::REG_W-1], kd};
      end
      mps_pkg::MUL_SPEED: begin
        mul_a = $signed(mps_pkg::MUL_A_W'(abs_speed));
        mul_b = $signed({1'b0, abs_ratio});
      end
      default: begin
      end
    endcase
  end

  assign prod_ext = {{(ACC_W - mps_pkg::PROD_W){prod[mps_pkg::PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= mul_a * mul_b;
    if (cmd.acc_load) begin
      acc <= prod_ext;
    end else if (cmd.acc_add) begin
      acc <= acc + prod_ext;
    end
  end

  // error divide: (|fast*ratio| - slow<<12) << FRAC_BITS / (|ratio| + 1.0)
  logic [mps_pkg::MAG_W-1:0] num_a;
  logic [mps_pkg::MAG_W-1:0] num_b;
  logic [mps_pkg::MAG_W-1:0] mag;
  logic                      mag_neg;
  logic [mps_pkg::DEN_W-1:0] den;
  logic [mps_pkg::Q_W-1:0]   quot;
  logic                      div_done;

  always_comb begin
    num_a   = prod[mps_pkg::MAG_W-1:0];
    num_b   = mps_pkg::MAG_W'({slow, {mps_pkg::RATIO_FRAC{1'b0}}});
    mag_neg = (num_a < num_b);
    mag     = mag_neg ? (num_b - num_a) : (num_a - num_b);
    den     = abs_ratio + mps_pkg::DEN_W'(1 << mps_pkg::RATIO_FRAC);
  end

  mps_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({mag, {mps_pkg::FRAC_BITS{1'b0}}}),
    .divisor  (den),
    .quotient (quot),
    .done     (div_done)
  );

  logic signed [mps_pkg::ERR_W-1:0] err_calc;
  logic signed [mps_pkg::ERR_W:0]   integ_sum;
  logic signed [mps_pkg::ERR_W:0]   integ_sat;

  always_comb begin
    if (ratio_zero) begin
      err_calc = '0;
    end else if (err_neg) begin
      err_calc = -$signed({1'b0, quot});
    end else begin
      err_calc = $signed({1'b0, quot});
    end
    integ_sum = (mps_pkg::ERR_W + 1)'(integ) + {err_calc[mps_pkg::ERR_W-1], err_calc};
    integ_sat = (integ_sum > INT_HI) ? INT_HI : ((integ_sum < INT_LO) ? INT_LO : integ_sum);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) err_neg <= mag_neg;
    if (cmd.err_upd) err <= err_calc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ    <= '0;
      last_err <= '0;
    end else begin
      if (cmd.err_upd) integ <= integ_sat[mps_pkg::INTEG_W-1:0];
      if (cmd.load_in && in_user[1]) begin
        last_err <= '0;
      end else if (cmd.last_upd) begin
        last_err <= err;
      end
    end
  end

  // drive shaping, then truncate and saturate
  logic signed [ACC_W-1:0] fd_base;
  logic signed [ACC_W-1:0] sd_base;
  logic signed [ACC_W-1:0] fd_raw;
  logic signed [ACC_W-1:0] sd_raw;
  logic                    sd_neg;

  always_comb begin
    fd_base = ($signed(ACC_W'(abs_speed)) <<< SF) - acc;
    sd_base = (prod_ext <<< (SF - mps_pkg::RATIO_FRAC)) + acc;
    sd_neg  = speed[mps_pkg::SPEED_W-1] ^ ratio[mps_pkg::REG_W-1];
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_en) begin
      if (speed_zero) begin
        fd_raw <= '0;
      end else begin
        fd_raw <= speed[mps_pkg::SPEED_W-1] ? -fd_base : fd_base;
      end
      if (speed_zero || ratio_zero) begin
        sd_raw <= '0;
      end else begin
        sd_raw <= sd_neg ? -sd_base : sd_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {sat_drive(trunc_sf(sd_raw)),
                   sat_drive(trunc_sf(fd_raw)),
                   sat_steer(trunc_sf(acc))};
    end
  end

  assign sts.div_done = div_done;
  assign sts.out_full = out_valid && !out_ready;

  `include "motor_pair_sync_pid_assert.svh"

  `MPS_ASSERT(a_dp_integ_in_range,
    ($signed((mps_pkg::ERR_W + 1)'(integ)) <= INT_HI) &&
    ($signed((mps_pkg::ERR_W + 1)'(integ)) >= INT_LO))

endmodule

// ===== rtl/motor_pair_sync_pid.sv =====
// ----------------------------------------------------------------------------
// motor_pair_sync_pid
// Motor pair sync error, clamped-integral PID steer and saturated drives.
// ----------------------------------------------------------------------------
//  channel  dir  fields (lsb first)
//  s_axis   in   tdata: fast_degrees, slow_degrees, drive_speed
//                tuser: mode, clear_history
//  m_axis   out  tdata: steer, fast_drive, slow_drive
//  cfg      in   cfg_index 0..6 selects the register, higher indexes ignored
//
//  One transaction at a time: no new input is taken while one is in flight.
//  The 31-step restoring divider computes the sync error; three passes
//  through one shared multiplier form the steer. rst is synchronous; it
//  restores the register defaults (ratio 1.0, gains 0) and zeroes integral
//  and last error. A result held by m_axis_tready low stalls the sequencer
//  in its last step; the next input is taken once that result is in the
//  output register.
// ----------------------------------------------------------------------------
module motor_pair_sync_pid (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [mps_pkg::IN_W-1:0]      s_axis_tdata,   // fast_degrees, slow_degrees, drive_speed
  input  logic [mps_pkg::USER_W-1:0]    s_axis_tuser,   // mode, clear_history
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [mps_pkg::OUT_W-1:0]     m_axis_tdata,   // steer, fast_drive, slow_drive
  input  logic                          cfg_we,
  input  logic [mps_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [mps_pkg::REG_W-1:0]     cfg_wdata
);

  mps_pkg::mps_cmd_t cmd;
  mps_pkg::mps_sts_t sts;

  mps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mps_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ===== test/motor_pair_sync_pid_tb.sv =====
// ----------------------------------------------------------------------------
// motor_pair_sync_pid_tb
// Drives sync samples into the motor pair PID through the input stream, keeps
// a bit-exact copy of the error division, clamped integral and PID steer, and
// compares every result field against it. Covers reset defaults, ratio and
// gain extremes, a long output stall, and random traffic under three
// idle/stall profiles.
// ----------------------------------------------------------------------------
module motor_pair_sync_pid_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mps_pkg::*;

  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;   // beyond the register file
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;
  localparam logic [DEGREE_BITS-1:0] DEG_MAX = '1;

  typedef struct {
    logic [DEGREE_BITS-1:0] fast;
    logic [DEGREE_BITS-1:0] slow;
    logic [SPEED_W-1:0]     speed;
    logic                   tank;
    logic                   clr;
  } sync_sample_t;

  // packed to match m_axis_tdata, steer in the low bits
  typedef struct packed {
    logic [DRIVE_W-1:0] slow_drive;
    logic [DRIVE_W-1:0] fast_drive;
    logic [STEER_W-1:0] steer;
  } drive_result_t;

  logic                 clk;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_W-1:0]      s_axis_tdata  = '0;   // fast_degrees, slow_degrees, drive_speed
  logic [USER_W-1:0]    s_axis_tuser  = '0;   // mode, clear_history
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;         // steer, fast_drive, slow_drive
  logic                 cfg_we        = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index     = '0;
  logic [REG_W-1:0]     cfg_wdata     = '0;

  motor_pair_sync_pid i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  // predictor state
  logic signed [REG_W-1:0] cfg_shadow [REG_CNT];
  longint                  integ_acc;
  longint                  prev_err;
  drive_result_t           expected_drives [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len      = 0;
  int hold_id       = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int mismatches    = 0;
  int unsigned idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint toward_zero(longint x, int s);
    return (x < 0) ? -((-x) >>> s) : (x >>> s);
  endfunction

  function automatic longint clamp(longint x, longint lo, longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic longint sgn(longint x);
    return (x > 0) ? 64'sd1 : ((x < 0) ? -64'sd1 : 64'sd0);
  endfunction

  // sync error, clamped integral, PID steer and both drives for one sample
  function automatic drive_result_t predict_drives(sync_sample_t s);
    longint ratio, absr, spd, abss, prod_fast, slow_q, den, mag, quo, rem;
    longint err, cap, lim, kp, ki, kd, steer_fx, fd, sd;
    logic   neg;
    drive_result_t r;
    ratio = cfg_shadow[REG_RATIO];
    absr  = (ratio < 0) ? -ratio : ratio;
    spd   = $signed(s.speed);
    abss  = (spd < 0) ? -spd : spd;
    if (s.clr) prev_err = 0;
    err = 0;
    if (ratio != 0) begin
      prod_fast = s.fast;
      prod_fast = prod_fast * absr;
      slow_q    = s.slow;
      slow_q    = slow_q << RATIO_FRAC;
      den       = absr + (64'sd1 << RATIO_FRAC);
      neg       = prod_fast < slow_q;
      mag       = neg ? slow_q - prod_fast : prod_fast - slow_q;
      quo       = mag / den;
      rem       = mag % den;
      err       = (quo << FRAC_BITS) + ((rem << FRAC_BITS) / den);
      cap       = neg ? (64'sd1 << 31) : (64'sd1 << 31) - 1;
      if (err > cap) err = cap;
      if (neg) err = -err;
    end
    lim       = longint'(INTEGRAL_LIMIT) << FRAC_BITS;
    integ_acc = clamp(integ_acc + err, -lim, lim);
    kp = cfg_shadow[s.tank ? REG_GP_TNK : REG_GP_NRM];
    ki = cfg_shadow[s.tank ? REG_GI_TNK : REG_GI_NRM];
    kd = cfg_shadow[s.tank ? REG_GD_TNK : REG_GD_NRM];
    steer_fx = err * kp + integ_acc * ki + (err - prev_err) * kd;
    prev_err = err;
    r.steer  = STEER_W'(clamp(toward_zero(steer_fx, SF), -32768, 32767));
    fd = ((abss << SF) - steer_fx) * sgn(spd);
    r.fast_drive = DRIVE_W'(clamp(toward_zero(fd, SF), -100, 100));
    sd = ((abss * absr) << (SF - RATIO_FRAC)) + steer_fx;
    sd = sd * sgn(spd) * sgn(ratio);
    r.slow_drive = DRIVE_W'(clamp(toward_zero(sd, SF), -100, 100));
    return r;
  endfunction

  function automatic sync_sample_t mk_sample(logic [DEGREE_BITS-1:0] f,
      logic [DEGREE_BITS-1:0] s, logic [SPEED_W-1:0] spd, logic tank, logic clr);
    sync_sample_t x;
    x.fast  = f;
    x.slow  = s;
    x.speed = spd;
    x.tank  = tank;
    x.clr   = clr;
    return x;
  endfunction

  function automatic logic [REG_W-1:0] pick_gain();
    case ($urandom_range(7))
      0:       return '0;
      1:       return 16'h8000;
      2:       return 16'h7FFF;
      7:       return REG_W'($urandom);
      default: return REG_W'($urandom_range(2048)) - 16'd1024;
    endcase
  endfunction

  // all stimulus tasks start and end on a falling edge
  task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_W-1:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    if (idx < REG_CNT) cfg_shadow[idx] = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_sample(sync_sample_t s);
    if ($urandom_range(99) < 5 && send_idle_pct > 0)
      repeat ($urandom_range(50, 1)) @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    s_axis_tdata  = {s.speed, s.slow, s.fast};
    s_axis_tuser  = {s.clr, s.tank};
    s_axis_tvalid = 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    expected_drives.push_back(predict_drives(s));
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  // wait for every outstanding result before touching the registers
  task automatic settle();
    while (expected_drives.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic test_reset_defaults();
    // ratio 1.0 and all gains zero after reset
    send_sample(mk_sample('0, '0, 8'sd0, 1'b0, 1'b0));
    send_sample(mk_sample(DEG_MAX, '0, 8'sd100, 1'b0, 1'b0));
    send_sample(mk_sample('0, DEG_MAX, -8'sd100, 1'b1, 1'b0));
    send_sample(mk_sample(DEG_MAX, DEG_MAX, 8'h80, 1'b0, 1'b1));
    send_sample(mk_sample(20'd12345, 20'd12000, 8'sd127, 1'b1, 1'b0));
  endtask

  task automatic test_ratio_and_gain_extremes();
    settle();
    write_reg(REG_GP_NRM, 16'h0100);
    write_reg(REG_GI_NRM, 16'h0010);
    write_reg(REG_GD_NRM, 16'hFFC0);
    write_reg(REG_GP_TNK, 16'h8000);
    write_reg(REG_GI_TNK, 16'h7FFF);
    write_reg(REG_GD_TNK, 16'h7FFF);
    send_sample(mk_sample(20'd1000, 20'd990, 8'sd50, 1'b0, 1'b1));
    send_sample(mk_sample(20'd1000, 20'd1010, 8'sd50, 1'b0, 1'b0));
    send_sample(mk_sample(DEG_MAX, '0, 8'sd100, 1'b0, 1'b0));   // integral hits +limit
    send_sample(mk_sample('0, DEG_MAX, -8'sd100, 1'b0, 1'b0));  // and swings to -limit
    send_sample(mk_sample(20'd500, 20'd500, 8'sd60, 1'b1, 1'b0));
    send_sample(mk_sample(DEG_MAX, '0, 8'sd127, 1'b1, 1'b1));
    send_sample(mk_sample('0, '0, 8'sd0, 1'b1, 1'b0));
    settle();
    write_reg(REG_UNUSED, 16'h0000);   // must not land in any register
    send_sample(mk_sample(20'd3000, 20'd2000, -8'sd40, 1'b0, 1'b0));
    settle();
    write_reg(REG_RATIO, 16'h0000);    // zero ratio: no error, slow drive zero
    send_sample(mk_sample(DEG_MAX, 20'd7, 8'sd90, 1'b0, 1'b0));
    send_sample(mk_sample(20'd5, DEG_MAX, -8'sd90, 1'b1, 1'b1));
    settle();
    write_reg(REG_RATIO, 16'h8000);
    send_sample(mk_sample(DEG_MAX, '0, 8'h80, 1'b0, 1'b0));
    send_sample(mk_sample(20'd100, 20'd800, 8'sd25, 1'b0, 1'b0));
    settle();
    write_reg(REG_RATIO, 16'h7FFF);
    send_sample(mk_sample(DEG_MAX, DEG_MAX, 8'sd100, 1'b1, 1'b0));
    send_sample(mk_sample(20'd4000, 20'd31999, -8'sd1, 1'b0, 1'b1));
    settle();
    write_reg(REG_RATIO, 16'h0001);
    send_sample(mk_sample('0, DEG_MAX, 8'sd10, 1'b0, 1'b0));
  endtask

  task automatic test_output_stall();
    settle();
    write_reg(REG_RATIO, 16'h1000);
    write_reg(REG_GP_NRM, 16'h0040);
    send_idle_pct = 0;
    hold_len      = 400;
    hold_id       = hold_id + 1;   // receiver picks this up on its next edge
    repeat (20)
      send_sample(mk_sample(DEGREE_BITS'($urandom), DEGREE_BITS'($urandom),
                            SPEED_W'($urandom), 1'(($urandom)), 1'b0));
  endtask

  task automatic test_random_traffic(int snd_pct, int rcv_pct, int chunks, int per_chunk);
    sync_sample_t s;
    longint       absr, slow_l;
    logic [REG_W-1:0] ratio;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    repeat (chunks) begin
      settle();
      case ($urandom_range(7))
        0:       ratio = '0;
        1:       ratio = 16'h8000;
        2:       ratio = 16'h7FFF;
        3, 4, 5: begin
          ratio = REG_W'($urandom_range(8192, 1024));
          if ($urandom_range(1)) ratio = -ratio;
        end
        default: ratio = REG_W'($urandom);
      endcase
      write_reg(REG_RATIO, ratio);
      write_reg(REG_GP_NRM, pick_gain());
      write_reg(REG_GI_NRM, pick_gain());
      write_reg(REG_GD_NRM, pick_gain());
      write_reg(REG_GP_TNK, pick_gain());
      write_reg(REG_GI_TNK, pick_gain());
      write_reg(REG_GD_TNK, pick_gain());
      absr = cfg_shadow[REG_RATIO];
      if (absr < 0) absr = -absr;
      repeat (per_chunk) begin
        s.fast = DEGREE_BITS'($urandom);
        case ($urandom_range(9))
          6, 7: begin
            s.fast = DEGREE_BITS'($urandom_range(4095));
            s.slow = DEGREE_BITS'($urandom_range(4095));
          end
          8, 9: s.slow = DEGREE_BITS'($urandom);
          default: begin
            // slow motor tracking the fast one closely
            slow_l = s.fast;
            slow_l = ((slow_l * absr) >>> RATIO_FRAC) + longint'($urandom_range(400)) - 200;
            s.slow = DEGREE_BITS'(clamp(slow_l, 0, longint'(DEG_MAX)));
          end
        endcase
        if ($urandom_range(99) < 85) s.speed = SPEED_W'($urandom_range(200)) - 8'd100;
        else                         s.speed = SPEED_W'($urandom);
        s.tank = 1'($urandom);
        s.clr  = ($urandom_range(9) == 0);
        send_sample(s);
      end
    end
  endtask

  // result side: random stalls plus an occasional long hold-off
  always @(negedge clk) begin : drive_receiver
    if (hold_id != hold_seen) begin
      hold_seen = hold_id;
      hold_left = hold_len;
    end
    if (hold_left > 0) begin
      m_axis_tready = 1'b0;
      hold_left--;
    end else begin
      m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_field(string name, longint want, longint got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    drive_result_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = drive_result_t'(m_axis_tdata);
      if (expected_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with none pending: steer %0d fast %0d slow %0d", $realtime,
                   $signed(got.steer), $signed(got.fast_drive), $signed(got.slow_drive));
      end else begin
        want = expected_drives.pop_front();
        report_field("steer", $signed(want.steer), $signed(got.steer));
        report_field("fast_drive", $signed(want.fast_drive), $signed(got.fast_drive));
        report_field("slow_drive", $signed(want.slow_drive), $signed(got.slow_drive));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : run_tests
    for (int i = 0; i < REG_CNT; i++) cfg_shadow[i] = '0;
    cfg_shadow[REG_RATIO] = RATIO_RESET;
    integ_acc = 0;
    prev_err  = 0;
    send_idle_pct = 30;
    recv_idle_pct = 46;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_ratio_and_gain_extremes();
    test_output_stall();
    test_random_traffic(30, 46, 5, 68);
    test_random_traffic(46, 30, 5, 68);
    test_random_traffic(0, 0, 5, 68);

    while (expected_drives.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (mismatches == 0 && expected_drives.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mps_pkg.sv
rtl/mps_div.sv
rtl/mps_ctrl.sv
rtl/mps_dp.sv
rtl/motor_pair_sync_pid.sv
test/motor_pair_sync_pid_tb.sv
